// ===== hdl/adaptive_window_velocity_estimator_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the adaptive window velocity estimator
// Shared property forms; each expects clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef ADAPTIVE_WINDOW_VELOCITY_ESTIMATOR_DEFINES_SVH
`define ADAPTIVE_WINDOW_VELOCITY_ESTIMATOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define AWVE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define AWVE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/awve_pkg.sv =====
// ----------------------------------------------------------------------------
// awve_pkg
// Types, field widths and register codes of the velocity estimator.
// ----------------------------------------------------------------------------
package awve_pkg;

  // Field widths
  localparam int ANGLE_W    = 16;
  localparam int THR_W      = 15;
  localparam int COEF_W     = 17;
  localparam int SCALE_W    = 16;
  localparam int SPAN_OUT_W = 5;
  localparam int VEL_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  typedef logic signed [ANGLE_W-1:0] angle_t;
  typedef logic signed [VEL_W-1:0]   vel_t;
  typedef logic [SPAN_OUT_W-1:0]     span_out_t;
  typedef logic [CFG_IDX_W-1:0]      cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0]     cfg_data_t;

  // Register indexes
  localparam cfg_idx_t CFG_MIN_DISP     = 2'd0;
  localparam cfg_idx_t CFG_FILTER_COEFF = 2'd1;
  localparam cfg_idx_t CFG_VEL_SCALE    = 2'd2;

  // Register reset values
  localparam logic [THR_W-1:0]   MIN_DISP_RST = 15'd104;
  localparam logic [COEF_W-1:0]  COEF_ONE     = 17'd65536;
  localparam logic [SCALE_W-1:0] SCALE_RST    = 16'd1;

  localparam span_out_t SPAN_OUT_MAX = 5'd31;

  // Divider status
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== hdl/awve_if.sv =====
// ----------------------------------------------------------------------------
// awve_if
// Valid/ready channels of the estimator: sample items, results, register
// writes.
// ----------------------------------------------------------------------------
interface awve_req_if;
  import awve_pkg::*;
  logic   valid;
  logic   ready;
  logic   mode;
  angle_t sample_angle;
  modport source (output valid, mode, sample_angle, input ready);
  modport sink   (input valid, mode, sample_angle, output ready);
endinterface

interface awve_rsp_if;
  import awve_pkg::*;
  logic      valid;
  logic      ready;
  angle_t    displacement;
  span_out_t span_samples;
  vel_t      velocity;
  vel_t      velocity_filtered;
  modport source (output valid, displacement, span_samples, velocity, velocity_filtered,
                  input ready);
  modport sink   (input valid, displacement, span_samples, velocity, velocity_filtered,
                  output ready);
endinterface

interface awve_cfg_if;
  import awve_pkg::*;
  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/adaptive_window_velocity_estimator.sv =====
// Store item: written in the cycle it is accepted, no result; one store a cycle while idle.
// Estimate item: the result is registered after these steps in order: newest read,
//   scan of the ring entries (one RAM read a cycle), multiply, divide at 4 bits a
//   cycle, filter, output.
// One item in flight: the next is accepted the cycle after the result is registered.
// Reset (synchronous): ring reads zero via per-entry valid bits, pointer, filter cleared.
// ----------------------------------------------------------------------------
// adaptive_window_velocity_estimator
// Ring of angle samples in RAM, window scan, velocity divide and low-pass.
// ----------------------------------------------------------------------------
`include "adaptive_window_velocity_estimator_defines.svh"

module adaptive_window_velocity_estimator #(
  parameter int DEPTH = 20
) (
  input  logic       clk,
  input  logic       rst,
  awve_req_if.sink   req,
  awve_rsp_if.source rsp,
  awve_cfg_if.sink   cfg
);
  import awve_pkg::*;

  localparam int AW     = $clog2(DEPTH);
  localparam int SPAN_W = $clog2(DEPTH);
  localparam int PROD_W = ANGLE_W + SCALE_W + 1;
  localparam int P_W    = VEL_W + COEF_W + 1;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_NEWEST = 4'd1;
  localparam logic [3:0] S_SCAN   = 4'd2;
  localparam logic [3:0] S_MUL    = 4'd3;
  localparam logic [3:0] S_DIVGO  = 4'd4;
  localparam logic [3:0] S_DIV    = 4'd5;
  localparam logic [3:0] S_FILT1  = 4'd6;
  localparam logic [3:0] S_FILT2  = 4'd7;
  localparam logic [3:0] S_OUT    = 4'd8;

  // Registers
  logic [3:0]          state;
  logic [AW-1:0]       wr_idx;
  logic [DEPTH-1:0]    valid_bits;
  vel_t                filt_reg;
  logic [THR_W-1:0]    min_disp;
  logic [COEF_W-1:0]   coeff;
  logic [SCALE_W-1:0]  scale;
  logic [AW-1:0]       scan_ptr;
  logic [AW-1:0]       eval_idx;
  logic                rd_ok;
  angle_t              newest;
  angle_t              disp;
  logic [SPAN_W-1:0]   span;
  logic signed [PROD_W-1:0] prod;
  logic                neg;
  vel_t                vel;
  logic signed [P_W-1:0] p1;
  logic signed [P_W-1:0] p2;
  logic                out_valid;
  angle_t              out_disp;
  span_out_t           out_span;
  vel_t                out_vel;
  vel_t                out_filt;

  // Combinational
  logic                req_acc;
  logic                store_acc;
  logic                est_acc;
  logic                cfg_acc;
  logic                out_free;
  logic [AW-1:0]       newest_addr;
  logic [AW-1:0]       rd_addr;
  logic [ANGLE_W-1:0]  ram_rd_data;
  angle_t              entry;
  angle_t              diff;
  logic [ANGLE_W-1:0]  mag;
  logic                qual;
  logic                scan_last;
  logic [PROD_W-1:0]   prod_abs;
  logic                div_start;
  div_stat_t           div_stat;
  logic [VEL_W-1:0]    quot;
  logic [COEF_W-1:0]   coeff_eff;
  logic [COEF_W-1:0]   coeff_rest;
  logic signed [P_W-1:0] blend;
  vel_t                filt_new;
  logic [SPAN_W+4:0]   span_wide;

  function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] p);
    ring_inc = (p == AW'(DEPTH - 1)) ? '0 : AW'(p + 1'b1);
  endfunction

  // Handshakes
  assign req.ready = (state == S_IDLE);
  assign req_acc   = req.valid && req.ready;
  assign store_acc = req_acc && !req.mode;
  assign est_acc   = req_acc && req.mode;
  assign cfg.ready = 1'b1;
  assign cfg_acc   = cfg.valid && cfg.ready;
  assign out_free  = !out_valid || rsp.ready;

  // Ring addressing: newest entry sits just behind the write pointer
  assign newest_addr = (wr_idx == '0) ? AW'(DEPTH - 1) : AW'(wr_idx - 1'b1);
  assign rd_addr     = (state == S_IDLE) ? newest_addr : scan_ptr;

  awve_ram #(
    .WIDTH (ANGLE_W),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (store_acc),
    .wr_addr (wr_idx),
    .wr_data (req.sample_angle),
    .rd_addr (rd_addr),
    .rd_data (ram_rd_data)
  );

  // Unwritten entries read as zero
  assign entry = rd_ok ? angle_t'(ram_rd_data) : '0;

  // Wrapped distance from the newest sample and threshold test
  assign diff      = newest - entry;
  assign mag       = diff[ANGLE_W-1] ? ANGLE_W'(-diff) : ANGLE_W'(diff);
  assign qual      = mag > {1'b0, min_disp};
  assign scan_last = !qual || (eval_idx == AW'(DEPTH - 2));

  // Divide the magnitude of displacement times scale by the span
  assign prod_abs  = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
  assign div_start = (state == S_DIVGO);

  awve_div #(
    .DVD_W (VEL_W),
    .DVS_W (SPAN_W),
    .STEP  (4)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod_abs[VEL_W-1:0]),
    .divisor  (span),
    .stat     (div_stat),
    .quotient (quot)
  );

  // Filter weights, blend and rounding shift
  assign coeff_eff  = (coeff > COEF_ONE) ? COEF_ONE : coeff;
  assign coeff_rest = COEF_ONE - coeff_eff;
  assign blend      = p1 + p2 + P_W'(32768);
  assign filt_new   = blend[VEL_W+15:16];

  // Saturate the reported span
  assign span_wide = (SPAN_W + 5)'(span);

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      min_disp <= MIN_DISP_RST;
      coeff    <= COEF_ONE;
      scale    <= SCALE_RST;
    end else if (cfg_acc) begin
      unique case (cfg.index)
        CFG_MIN_DISP:     min_disp <= cfg.data[THR_W-1:0];
        CFG_FILTER_COEFF: coeff    <= cfg.data[COEF_W-1:0];
        CFG_VEL_SCALE:    scale    <= cfg.data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Store items: advance the write pointer, mark the entry written
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx     <= '0;
      valid_bits <= '0;
    end else if (store_acc) begin
      wr_idx             <= ring_inc(wr_idx);
      valid_bits[wr_idx] <= 1'b1;
    end
  end

  // Valid bit is registered alongside the RAM read
  always_ff @(posedge clk) begin
    rd_ok <= valid_bits[rd_addr];
  end

  // Estimate sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      filt_reg  <= '0;
      out_valid <= 1'b0;
    end else begin
      // Drop the taken result unless a new one is loaded this cycle
      if (rsp.ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (est_acc) begin
            scan_ptr <= wr_idx;
            state    <= S_NEWEST;
          end
        end
        S_NEWEST: begin
          newest   <= entry;
          scan_ptr <= ring_inc(scan_ptr);
          eval_idx <= '0;
          state    <= S_SCAN;
        end
        S_SCAN: begin
          // Oldest entry always sets the fallback; later ones only while they qualify
          if (eval_idx == '0 || qual) begin
            disp <= diff;
            span <= SPAN_W'(DEPTH - 1) - eval_idx;
          end
          scan_ptr <= ring_inc(scan_ptr);
          eval_idx <= eval_idx + 1'b1;
          if (scan_last) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= $signed(disp) * $signed({1'b0, scale});
          state <= S_DIVGO;
        end
        S_DIVGO: begin
          neg   <= prod[PROD_W-1];
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_stat.done) begin
            vel   <= neg ? VEL_W'(-quot) : VEL_W'(quot);
            state <= S_FILT1;
          end
        end
        S_FILT1: begin
          p1    <= $signed(vel) * $signed({1'b0, coeff_eff});
          state <= S_FILT2;
        end
        S_FILT2: begin
          p2    <= $signed(filt_reg) * $signed({1'b0, coeff_rest});
          state <= S_OUT;
        end
        S_OUT: begin
          // Hold until the output register is free
          if (out_free) begin
            filt_reg  <= filt_new;
            out_valid <= 1'b1;
            out_disp  <= disp;
            out_span  <= (span_wide > (SPAN_W + 5)'(SPAN_OUT_MAX)) ? SPAN_OUT_MAX
                                                                   : span_wide[4:0];
            out_vel   <= vel;
            out_filt  <= filt_new;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid             = out_valid;
  assign rsp.displacement      = out_disp;
  assign rsp.span_samples      = out_span;
  assign rsp.velocity          = out_vel;
  assign rsp.velocity_filtered = out_filt;

  // Checks
  `AWVE_ASSERT_NEXT(a_est_starts_scan, est_acc, state == S_NEWEST, "estimate did not scan")
  `AWVE_ASSERT_NOW(a_wr_idx_range, 1'b1, wr_idx <= AW'(DEPTH - 1), "write pointer beyond ring")
  `AWVE_ASSERT_NOW(a_scan_idx_range, state == S_SCAN, eval_idx <= AW'(DEPTH - 2), "scan overran")
  `AWVE_ASSERT_NOW(a_rsp_from_out, $rose(rsp.valid), $past(state) == S_OUT, "stray result")
  `AWVE_ASSERT_NEXT(a_div_runs, div_start, div_stat.busy, "divider did not start")

endmodule

// ===== hdl/awve_ram.sv =====
// ----------------------------------------------------------------------------
// awve_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module awve_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 20,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on enable, read every cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hdl/awve_div.sv =====
// ----------------------------------------------------------------------------
// awve_div
// Unsigned restoring divider, STEP quotient bits per cycle.
// ----------------------------------------------------------------------------
module awve_div #(
  parameter int DVD_W = 32,
  parameter int DVS_W = 5,
  parameter int STEP  = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DVD_W-1:0]      dividend,
  input  logic [DVS_W-1:0]      divisor,
  output awve_pkg::div_stat_t   stat,
  output logic [DVD_W-1:0]      quotient
);
  import awve_pkg::*;

  localparam int ROUNDS = DVD_W / STEP;
  localparam int CNT_W  = $clog2(ROUNDS + 1);

  logic [DVD_W-1:0] work;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [CNT_W-1:0] rounds;
  logic             busy;
  logic             done;
  logic [DVD_W-1:0] work_next;
  logic [DVS_W-1:0] rem_next;

  // Retire STEP quotient bits: shift in a dividend bit, subtract if it fits
  always_comb begin
    logic [DVS_W:0]   r_sh;
    logic [DVS_W-1:0] r;
    logic [DVD_W-1:0] q;
    r = rem;
    q = work;
    for (int k = 0; k < STEP; k++) begin
      r_sh = {r, q[DVD_W-1]};
      q    = {q[DVD_W-2:0], 1'b0};
      if (r_sh >= {1'b0, dvs}) begin
        r    = DVS_W'(r_sh - {1'b0, dvs});
        q[0] = 1'b1;
      end else begin
        r = r_sh[DVS_W-1:0];
      end
    end
    work_next = q;
    rem_next  = r;
  end

  // Load on start, advance while busy
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        work   <= dividend;
        rem    <= '0;
        dvs    <= divisor;
        rounds <= CNT_W'(ROUNDS);
        busy   <= 1'b1;
      end else if (busy) begin
        work   <= work_next;
        rem    <= rem_next;
        rounds <= rounds - 1'b1;
        if (rounds == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = work;

endmodule
